>>> rtl/ptfu_pkg.sv
// ============================================================================
// ptfu_pkg: shared definitions of the position table
// Status codes, register address, table entry layout and the status record
// passed from the key scanner to the sequencer.
// ============================================================================
`default_nettype none

package ptfu_pkg;

    localparam int CONTRACTS_DEF = 64;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_OWNER = 3'd0;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [63:0] net;
        logic        stamped;
        logic [63:0] stamp_time;
        logic [63:0] stamp_seq;
    } ptfu_entry_t;

    typedef struct packed {
        logic done;
        logic hit;
    } ptfu_scan_t;

endpackage

`default_nettype wire

>>> rtl/position_table_fill_update_top.sv
// ============================================================================
// position_table_fill_update_top: net position table for one trader
// Applies fills to and looks up per-contract signed net positions.
// ============================================================================
// An item is taken only while the block is idle. A fill from a trader other
// than the owner skips the search and goes straight to the result hand-off.
// Any other item first searches the key memory one stored key per cycle, up
// to the number of entries in use; a fill then goes through the entry read
// (for a key already held), the single shared 64-bit add and subtract unit
// and the result hand-off, and a lookup through the entry read on a hit and
// the result hand-off. Entries are never removed, so the fill count marks the
// valid entries and no clearing pass is needed after reset. A result waiting
// at the output does not stop the next item from being taken.
`default_nettype none

module position_table_fill_update_top #(
    parameter int CONTRACTS = ptfu_pkg::CONTRACTS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [ptfu_pkg::PADDR_W-1:0]    paddr,
    input  wire  [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire                             mode,
    input  wire  [31:0]                     fill_trader,
    input  wire  [31:0]                     contract_key,
    input  wire                             sell_side,
    input  wire  [63:0]                     fill_units,
    input  wire  [63:0]                     exec_time,
    input  wire  [63:0]                     fill_seq,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [2:0]                      status,
    output logic signed [63:0]              net_position,
    output logic                            has_update,
    output logic [63:0]                     last_time,
    output logic [63:0]                     last_seq
);
    import ptfu_pkg::*;

    localparam int IW = (CONTRACTS > 1) ? $clog2(CONTRACTS) : 1;
    localparam int CW = $clog2(CONTRACTS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_CALC   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [31:0]   owner_reg;
    logic [CW-1:0] used_count_reg;
    logic          out_valid_reg;

    logic          mode_reg;
    logic [31:0]   key_reg;
    logic          sell_reg;
    logic [63:0]   qty_reg;
    logic [63:0]   time_reg;
    logic [63:0]   seq_reg;
    logic [IW-1:0] slot_reg;
    ptfu_entry_t   ent_reg;
    logic [2:0]    res_status_reg;
    ptfu_entry_t   res_entry_reg;
    logic [2:0]    out_status_reg;
    ptfu_entry_t   out_entry_reg;

    ptfu_scan_t    scan;
    logic [IW-1:0] scan_idx;
    ptfu_entry_t   ram_rd_data;
    ptfu_entry_t   upd_entry;

    logic          ld_item;
    logic          scan_start;
    logic          key_wr;
    logic          ram_rd;
    logic          ram_wr;
    logic          ld_ent_zero;
    logic          ld_ent_ram;
    logic          ld_res;
    logic          ld_out;
    logic [2:0]    res_status;
    ptfu_entry_t   res_entry;
    logic          table_full;
    logic          cfg_wr;

    logic [63:0]   sum;
    logic          ovf;

    // Shared add and subtract unit with signed range check.
    assign sum = sell_reg ? (ent_reg.net - qty_reg) : (ent_reg.net + qty_reg);
    assign ovf = qty_reg[63]
              || (!sell_reg && !ent_reg.net[63] && sum[63])
              || ( sell_reg &&  ent_reg.net[63] && !sum[63]);

    always_comb
    begin
        upd_entry            = ent_reg;
        if (!ovf)
        begin
            upd_entry.net        = sum;
            upd_entry.stamped    = 1'b1;
            upd_entry.stamp_time = time_reg;
            upd_entry.stamp_seq  = seq_reg;
        end
    end

    assign table_full = (used_count_reg == CW'(CONTRACTS));
    assign in_ready   = (state_reg == S_IDLE);
    assign ld_item    = in_valid && in_ready;

    always_comb
    begin
        state_next  = state_reg;
        scan_start  = 1'b0;
        key_wr      = 1'b0;
        ram_rd      = 1'b0;
        ram_wr      = 1'b0;
        ld_ent_zero = 1'b0;
        ld_ent_ram  = 1'b0;
        ld_res      = 1'b0;
        ld_out      = 1'b0;
        res_status  = ST_OK;
        res_entry   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!mode && (fill_trader != owner_reg))
                    begin
                        ld_res     = 1'b1;
                        res_status = ST_MISMATCH;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan.done)
                begin
                    if (scan.hit)
                    begin
                        ram_rd     = 1'b1;
                        state_next = S_RDWAIT;
                    end
                    else if (mode_reg)
                    begin
                        ld_res     = 1'b1;
                        res_status = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                    else if (table_full)
                    begin
                        ld_res     = 1'b1;
                        res_status = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        key_wr      = 1'b1;
                        ld_ent_zero = 1'b1;
                        state_next  = S_CALC;
                    end
                end
            end
            S_RDWAIT:
            begin
                if (mode_reg)
                begin
                    ld_res     = 1'b1;
                    res_entry  = ram_rd_data;
                    state_next = S_DONE;
                end
                else
                begin
                    ld_ent_ram = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                ram_wr     = 1'b1;
                ld_res     = 1'b1;
                res_status = ovf ? ST_OVERFLOW : ST_OK;
                res_entry  = upd_entry;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ld_out     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ADDR_OWNER[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            owner_reg      <= '0;
            used_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                owner_reg <= pwdata;
            end
            if (key_wr)
            begin
                used_count_reg <= used_count_reg + CW'(1);
            end
            if (ld_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_item)
        begin
            mode_reg <= mode;
            key_reg  <= contract_key;
            sell_reg <= sell_side;
            qty_reg  <= fill_units;
            time_reg <= exec_time;
            seq_reg  <= fill_seq;
        end
        if ((state_reg == S_SCAN) && scan.done)
        begin
            slot_reg <= scan.hit ? scan_idx : used_count_reg[IW-1:0];
        end
        if (ld_ent_zero)
        begin
            ent_reg <= '0;
        end
        else if (ld_ent_ram)
        begin
            ent_reg <= ram_rd_data;
        end
        if (ld_res)
        begin
            res_status_reg <= res_status;
            res_entry_reg  <= res_entry;
        end
        if (ld_out)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
        end
    end

    ptfu_key_scan #(
        .CONTRACTS (CONTRACTS)
    ) u_key_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .key     (key_reg),
        .count   (used_count_reg),
        .wr_en   (key_wr),
        .wr_addr (used_count_reg[IW-1:0]),
        .wr_key  (key_reg),
        .result  (scan),
        .hit_idx (scan_idx)
    );

    ptfu_entry_ram #(
        .CONTRACTS (CONTRACTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (slot_reg),
        .wr_data (upd_entry),
        .rd_en   (ram_rd),
        .rd_addr (scan_idx),
        .rd_data (ram_rd_data)
    );

    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == ADDR_OWNER[2]) ? owner_reg : 32'd0;
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign net_position = out_entry_reg.net;
    assign has_update   = out_entry_reg.stamped;
    assign last_time    = out_entry_reg.stamp_time;
    assign last_seq     = out_entry_reg.stamp_seq;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= CW'(CONTRACTS))
        else $error("fill count beyond table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        key_wr |-> !table_full && !scan.hit)
        else $error("insertion into a full table or over a matching key");

    assert property (@(posedge clk) disable iff (!rst_n)
        (used_count_reg != $past(used_count_reg))
        |-> (used_count_reg == $past(used_count_reg) + CW'(1)))
        else $error("fill count changed by other than one");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the hand-off state");
`endif

endmodule

`default_nettype wire

>>> rtl/ptfu_key_scan.sv
// ============================================================================
// ptfu_key_scan: contract key memory and sequential search
// Holds the contract key of every used entry and compares one stored key per
// cycle against the key of the current item until a match or the fill count.
// ============================================================================
`default_nettype none

module ptfu_key_scan #(
    parameter int CONTRACTS = ptfu_pkg::CONTRACTS_DEF
) (
    input  wire                                            clk,
    input  wire                                            rst_n,
    input  wire                                            start,
    input  wire  [31:0]                                    key,
    input  wire  [$clog2(CONTRACTS+1)-1:0]                 count,
    input  wire                                            wr_en,
    input  wire  [((CONTRACTS > 1) ? $clog2(CONTRACTS) : 1)-1:0] wr_addr,
    input  wire  [31:0]                                    wr_key,
    output ptfu_pkg::ptfu_scan_t                           result,
    output logic [((CONTRACTS > 1) ? $clog2(CONTRACTS) : 1)-1:0] hit_idx
);
    import ptfu_pkg::*;

    localparam int IW = (CONTRACTS > 1) ? $clog2(CONTRACTS) : 1;
    localparam int CW = $clog2(CONTRACTS + 1);

    logic [31:0]   key_mem [CONTRACTS];
    logic [31:0]   rd_key_reg;
    logic          busy_reg;
    logic [CW-1:0] addr_reg;
    logic          pend_reg;
    logic [IW-1:0] pend_idx_reg;
    logic          more;
    logic          match;
    logic          done;
    logic          rd_en;

    assign more  = addr_reg < count;
    assign match = pend_reg && (rd_key_reg == key);
    assign done  = busy_reg && (match || (!pend_reg && !more));
    assign rd_en = busy_reg && !done && more;

    assign result.done = done;
    assign result.hit  = match;
    assign hit_idx     = pend_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            addr_reg <= '0;
            pend_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
            pend_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
                pend_reg <= 1'b0;
            end
            else
            begin
                pend_reg <= more;
                if (more)
                begin
                    addr_reg <= addr_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (rd_en)
        begin
            rd_key_reg   <= key_mem[addr_reg[IW-1:0]];
            pend_idx_reg <= addr_reg[IW-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/ptfu_entry_ram.sv
// ============================================================================
// ptfu_entry_ram: position entry memory
// One write port and one registered read port over the entry records.
// ============================================================================
`default_nettype none

module ptfu_entry_ram #(
    parameter int CONTRACTS = ptfu_pkg::CONTRACTS_DEF
) (
    input  wire                                                  clk,
    input  wire                                                  wr_en,
    input  wire  [((CONTRACTS > 1) ? $clog2(CONTRACTS) : 1)-1:0] wr_addr,
    input  wire  ptfu_pkg::ptfu_entry_t                          wr_data,
    input  wire                                                  rd_en,
    input  wire  [((CONTRACTS > 1) ? $clog2(CONTRACTS) : 1)-1:0] rd_addr,
    output ptfu_pkg::ptfu_entry_t                                rd_data
);
    import ptfu_pkg::*;

    ptfu_entry_t entry_mem [CONTRACTS];
    ptfu_entry_t rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> verif/position_table_fill_update_monitor.sv
// ============================================================================
// position_table_fill_update_monitor: result checker for the position table
// Watches the register port and both item channels, keeps its own copy of the
// owner and of the contract table, works out the result of every accepted
// item and compares each returned result with the oldest one still awaited.
// ============================================================================

package position_tb_pkg;

    localparam logic MODE_FILL   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;
    localparam logic SIDE_BUY    = 1'b0;
    localparam logic SIDE_SELL   = 1'b1;

endpackage

module position_table_fill_update_monitor #(
    parameter int CONTRACTS = ptfu_pkg::CONTRACTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [ptfu_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          mode,
    input  logic [31:0]                   fill_trader,
    input  logic [31:0]                   contract_key,
    input  logic                          sell_side,
    input  logic [63:0]                   fill_units,
    input  logic [63:0]                   exec_time,
    input  logic [63:0]                   fill_seq,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [2:0]                    status,
    input  logic signed [63:0]            net_position,
    input  logic                          has_update,
    input  logic [63:0]                   last_time,
    input  logic [63:0]                   last_seq,
    output int                            mismatch_count,
    output int                            reports_pending,
    output logic [4:0][31:0]              status_tally
);

    import ptfu_pkg::*;
    import position_tb_pkg::*;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [63:0] net;
        logic               stamped;
        logic [63:0]        stamp_time;
        logic [63:0]        stamp_seq;
    } position_report_t;

    logic [31:0]      owner_id;
    logic             slot_used    [CONTRACTS];
    logic [31:0]      slot_key     [CONTRACTS];
    logic [63:0]      slot_net     [CONTRACTS];
    logic             slot_stamped [CONTRACTS];
    logic [63:0]      slot_time    [CONTRACTS];
    logic [63:0]      slot_seq     [CONTRACTS];
    int               slots_filled;
    position_report_t expected_reports [$];

    function automatic position_report_t slot_report(input logic [2:0] code, input int slot);
        position_report_t rep;
        rep = '0;
        rep.status = code;
        if (slot >= 0)
        begin
            rep.net        = slot_net[slot];
            rep.stamped    = slot_stamped[slot];
            rep.stamp_time = slot_time[slot];
            rep.stamp_seq  = slot_seq[slot];
        end
        return rep;
    endfunction

    function automatic position_report_t apply_item(
        input logic        mode_in,
        input logic [31:0] trader_in,
        input logic [31:0] key_in,
        input logic        sell_in,
        input logic [63:0] units_in,
        input logic [63:0] time_in,
        input logic [63:0] seq_in
    );
        int          slot;
        int          idx;
        logic [63:0] base;
        logic [63:0] moved;
        logic        out_of_range;
        slot = -1;
        for (idx = CONTRACTS - 1; idx >= 0; idx--)
        begin
            if (slot_used[idx] && slot_key[idx] == key_in)
                slot = idx;
        end
        if (mode_in == MODE_LOOKUP)
            return slot_report((slot < 0) ? ST_NOTFOUND : ST_OK, slot);
        if (trader_in != owner_id)
            return slot_report(ST_MISMATCH, -1);
        if (slot < 0)
        begin
            if (slots_filled >= CONTRACTS)
                return slot_report(ST_FULL, -1);
            for (idx = CONTRACTS - 1; idx >= 0; idx--)
            begin
                if (!slot_used[idx])
                    slot = idx;
            end
            slot_used[slot]    = 1'b1;
            slot_key[slot]     = key_in;
            slot_net[slot]     = '0;
            slot_stamped[slot] = 1'b0;
            slot_time[slot]    = '0;
            slot_seq[slot]     = '0;
            slots_filled++;
        end
        if (units_in[63])
            return slot_report(ST_OVERFLOW, slot);
        base = slot_net[slot];
        if (sell_in == SIDE_SELL)
        begin
            moved        = base - units_in;
            out_of_range = base[63] && !moved[63];
        end
        else
        begin
            moved        = base + units_in;
            out_of_range = !base[63] && moved[63];
        end
        if (out_of_range)
            return slot_report(ST_OVERFLOW, slot);
        slot_net[slot]     = moved;
        slot_stamped[slot] = 1'b1;
        slot_time[slot]    = time_in;
        slot_seq[slot]     = seq_in;
        return slot_report(ST_OK, slot);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        position_report_t want;
        position_report_t got;
        logic             bad;
        int               idx;
        if (!rst_n)
        begin
            owner_id     = '0;
            slots_filled = 0;
            for (idx = 0; idx < CONTRACTS; idx++)
                slot_used[idx] = 1'b0;
            expected_reports.delete();
            mismatch_count = 0;
            status_tally   = '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == ADDR_OWNER[2])
                owner_id = pwdata;
            if (out_valid && out_ready)
            begin
                got = {status, net_position, has_update, last_time, last_seq};
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: result with none awaited: status %0d net %0d",
                             $time, got.status, got.net);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    bad  = 1'b0;
                    status_tally[want.status] = status_tally[want.status] + 1;
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, got.status);
                        bad = 1'b1;
                    end
                    if (got.net !== want.net)
                    begin
                        $display("%0t: net_position expected %0d, got %0d",
                                 $time, want.net, got.net);
                        bad = 1'b1;
                    end
                    if (got.stamped !== want.stamped)
                    begin
                        $display("%0t: has_update expected %0b, got %0b",
                                 $time, want.stamped, got.stamped);
                        bad = 1'b1;
                    end
                    if (got.stamp_time !== want.stamp_time)
                    begin
                        $display("%0t: last_time expected %h, got %h",
                                 $time, want.stamp_time, got.stamp_time);
                        bad = 1'b1;
                    end
                    if (got.stamp_seq !== want.stamp_seq)
                    begin
                        $display("%0t: last_seq expected %h, got %h",
                                 $time, want.stamp_seq, got.stamp_seq);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatch_count++;
                end
            end
            if (in_valid && in_ready)
                expected_reports.push_back(apply_item(mode, fill_trader, contract_key,
                                                      sell_side, fill_units, exec_time,
                                                      fill_seq));
        end
        reports_pending = expected_reports.size();
    end

endmodule

>>> verif/position_table_fill_update_top_tb.sv
// ============================================================================
// position_table_fill_update_top_tb: test bench for the position table
// Drives directed and random fill and lookup items in bursts against a
// stalling receiver, rewrites the owner trader between phases and takes the
// verdict from the result checker placed beside the block.
// ============================================================================

module position_table_fill_update_top_tb;

    import ptfu_pkg::*;
    import position_tb_pkg::*;

    localparam int          CONTRACTS     = CONTRACTS_DEF;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          RANDOM_PHASES = 6;
    localparam int          PHASE_ORDERS  = 325;
    localparam int          HOT_KEYS      = 40;
    localparam int          PACE_STEADY   = 0;
    localparam int          PACE_LIGHT    = 1;
    localparam int          PACE_HEAVY    = 2;
    localparam int          PACE_PERIODIC = 3;
    localparam logic [63:0] POS_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        mode;
        logic [31:0] trader;
        logic [31:0] key;
        logic        sell;
        logic [63:0] units;
        logic [63:0] stamp_time;
        logic [63:0] stamp_seq;
    } fill_order_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [ptfu_pkg::PADDR_W-1:0]  paddr        = '0;
    logic [31:0]                   pwdata       = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          in_valid     = 1'b0;
    logic                          in_ready;
    logic                          mode         = 1'b0;
    logic [31:0]                   fill_trader  = '0;
    logic [31:0]                   contract_key = '0;
    logic                          sell_side    = 1'b0;
    logic [63:0]                   fill_units   = '0;
    logic [63:0]                   exec_time    = '0;
    logic [63:0]                   fill_seq     = '0;
    logic                          out_valid;
    logic                          out_ready    = 1'b0;
    logic [2:0]                    status;
    logic signed [63:0]            net_position;
    logic                          has_update;
    logic [63:0]                   last_time;
    logic [63:0]                   last_seq;

    int               mismatch_count;
    int               reports_pending;
    logic [4:0][31:0] status_tally;
    int               cycle_count  = 0;
    int               burst_left   = 0;
    int               orders_sent  = 0;
    int               owner_writes = 0;
    int               pace         = PACE_STEADY;
    int               pace_span    = 0;
    logic [31:0]      owner_id     = '0;
    logic [31:0]      hot_keys [HOT_KEYS];

    position_table_fill_update_top #(.CONTRACTS(CONTRACTS)) uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .fill_trader(fill_trader), .contract_key(contract_key),
        .sell_side(sell_side), .fill_units(fill_units), .exec_time(exec_time),
        .fill_seq(fill_seq),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .net_position(net_position), .has_update(has_update),
        .last_time(last_time), .last_seq(last_seq)
    );

    position_table_fill_update_monitor #(.CONTRACTS(CONTRACTS)) ledger_watch (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .fill_trader(fill_trader), .contract_key(contract_key),
        .sell_side(sell_side), .fill_units(fill_units), .exec_time(exec_time),
        .fill_seq(fill_seq),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .net_position(net_position), .has_update(has_update),
        .last_time(last_time), .last_seq(last_seq),
        .mismatch_count(mismatch_count), .reports_pending(reports_pending),
        .status_tally(status_tally)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cycle limit reached with %0d results outstanding", reports_pending);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (pace_span == 0)
        begin
            pace_span <= $urandom_range(16, 160);
            pace      <= $urandom_range(PACE_STEADY, PACE_PERIODIC);
        end
        else
        begin
            pace_span <= pace_span - 1;
        end
        case (pace)
            PACE_STEADY: out_ready <= 1'b1;
            PACE_LIGHT:  out_ready <= ($urandom_range(0, 3) != 0);
            PACE_HEAVY:  out_ready <= ($urandom_range(0, 3) == 0);
            default:     out_ready <= ((pace_span % 9) < 5);
        endcase
    end

    function automatic fill_order_t make_order(
        input logic        mode_in,
        input logic [31:0] trader_in,
        input logic [31:0] key_in,
        input logic        sell_in,
        input logic [63:0] units_in,
        input logic [63:0] time_in,
        input logic [63:0] seq_in
    );
        return '{mode_in, trader_in, key_in, sell_in, units_in, time_in, seq_in};
    endfunction

    task automatic send_order(input fill_order_t order);
        int gap;
        in_valid     <= 1'b1;
        mode         <= order.mode;
        fill_trader  <= order.trader;
        contract_key <= order.key;
        sell_side    <= order.sell;
        fill_units   <= order.units;
        exec_time    <= order.stamp_time;
        fill_seq     <= order.stamp_seq;
        do
            @(posedge clk);
        while (!in_ready);
        orders_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(negedge clk);
        while (reports_pending != 0)
            @(negedge clk);
    endtask

    task automatic write_owner(input logic [31:0] value);
        wait_quiet();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_OWNER;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        owner_id = value;
        owner_writes++;
    endtask

    initial
    begin
        fill_order_t order;
        logic [31:0] phase_owner [RANDOM_PHASES];
        int          phase;
        int          n;
        int          r;
        int          k;

        for (k = 0; k < HOT_KEYS; k++)
            hot_keys[k] = $urandom;
        phase_owner[0] = $urandom;
        phase_owner[1] = 32'hFFFF_FFFF;
        phase_owner[2] = $urandom;
        phase_owner[3] = 32'h0000_0000;
        phase_owner[4] = $urandom;
        phase_owner[5] = 32'h8000_0001;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The owner is still at its reset value of zero here.
        send_order(make_order(MODE_LOOKUP, 32'h0, 32'h0, SIDE_BUY, 64'h0, 64'h0, 64'h0));
        send_order(make_order(MODE_FILL, 32'h0, 32'h0, SIDE_BUY, 64'h0, 64'h1, 64'h2));
        send_order(make_order(MODE_FILL, 32'hFFFF_FFFF, 32'h0, SIDE_BUY, 64'h5,
                              64'h3, 64'h4));
        send_order(make_order(MODE_FILL, 32'h0, 32'hFFFF_FFFF, SIDE_BUY, POS_MAX,
                              ALL_ONES, ALL_ONES));
        send_order(make_order(MODE_FILL, 32'h0, 32'hFFFF_FFFF, SIDE_BUY, 64'h1,
                              64'h10, 64'h11));
        send_order(make_order(MODE_FILL, 32'h0, 32'hFFFF_FFFF, SIDE_SELL, POS_MAX,
                              64'h12, 64'h13));
        send_order(make_order(MODE_FILL, 32'h0, 32'hFFFF_FFFF, SIDE_SELL, POS_MAX,
                              64'h14, 64'h15));
        send_order(make_order(MODE_FILL, 32'h0, 32'hFFFF_FFFF, SIDE_SELL, 64'h1,
                              64'h16, 64'h17));
        send_order(make_order(MODE_FILL, 32'h0, 32'hFFFF_FFFF, SIDE_SELL, 64'h1,
                              64'h18, 64'h19));
        send_order(make_order(MODE_FILL, 32'h0, 32'hFFFF_FFFF, SIDE_BUY,
                              64'h8000_0000_0000_0000, 64'h1A, 64'h1B));
        send_order(make_order(MODE_FILL, 32'h0, 32'h5A5A_5A5A, SIDE_BUY, ALL_ONES,
                              64'h1C, 64'h1D));
        send_order(make_order(MODE_LOOKUP, 32'h1234_5678, 32'h5A5A_5A5A, SIDE_SELL,
                              ALL_ONES, 64'h0, 64'h0));
        send_order(make_order(MODE_LOOKUP, 32'h0, 32'hFFFF_FFFF, SIDE_BUY, 64'h0,
                              64'h0, 64'h0));
        send_order(make_order(MODE_FILL, 32'h0, 32'h5A5A_5A5A, SIDE_SELL, 64'h0,
                              64'h0, 64'h0));
        send_order(make_order(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, SIDE_BUY, 64'h0,
                              64'h0, 64'h0));

        write_owner(32'hFFFF_FFFF);
        send_order(make_order(MODE_FILL, 32'h0, 32'h0, SIDE_BUY, 64'h7, 64'h20, 64'h21));
        send_order(make_order(MODE_FILL, 32'hFFFF_FFFF, 32'h0, SIDE_SELL, POS_MAX,
                              64'h22, 64'h23));
        send_order(make_order(MODE_FILL, 32'hFFFF_FFFF, 32'hA5A5_A5A5, SIDE_SELL,
                              64'h3, 64'h24, 64'h25));
        send_order(make_order(MODE_LOOKUP, 32'h0, 32'hA5A5_A5A5, SIDE_BUY, 64'h0,
                              64'h0, 64'h0));

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_owner(phase_owner[phase]);
            for (n = 0; n < PHASE_ORDERS; n++)
            begin
                order.mode = ($urandom_range(0, 4) == 0) ? MODE_LOOKUP : MODE_FILL;
                r = $urandom_range(0, 99);
                if (r < 85)
                    order.trader = owner_id;
                else if (r < 93)
                    order.trader = $urandom;
                else
                    order.trader = owner_id ^ (32'h1 << $urandom_range(0, 31));
                r = $urandom_range(0, 99);
                if (r < 55)
                    order.key = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
                else if (r < 70)
                    order.key = hot_keys[$urandom_range(0, 3)];
                else if (r < 85)
                    order.key = $urandom;
                else
                    order.key = hot_keys[$urandom_range(0, HOT_KEYS / 2)];
                order.sell = ($urandom_range(0, 1) != 0) ? SIDE_SELL : SIDE_BUY;
                r = $urandom_range(0, 99);
                if (r < 30)
                    order.units = 64'($urandom_range(0, 1000));
                else if (r < 52)
                    order.units = {1'b0, 31'($urandom), 32'($urandom)};
                else if (r < 66)
                    order.units = POS_MAX - 64'($urandom_range(0, 3));
                else if (r < 76)
                    order.units = {2'b01, 30'($urandom), 32'($urandom)};
                else if (r < 84)
                    order.units = {1'b1, 31'($urandom), 32'($urandom)};
                else if (r < 91)
                    order.units = 64'h0;
                else
                    order.units = {32'($urandom), 32'($urandom)};
                r = $urandom_range(0, 19);
                order.stamp_time = (r == 0) ? 64'h0 : (r == 1) ? ALL_ONES :
                                   {32'($urandom), 32'($urandom)};
                r = $urandom_range(0, 19);
                order.stamp_seq  = (r == 0) ? 64'h0 : (r == 1) ? ALL_ONES :
                                   {32'($urandom), 32'($urandom)};
                send_order(order);
            end
        end

        wait_quiet();
        repeat (CONTRACTS + 10) @(posedge clk);

        $display("sent %0d items under %0d owner settings in %0d cycles",
                 orders_sent, owner_writes + 1, cycle_count);
        $display("results: ok %0d, owner mismatch %0d, overflow %0d, table full %0d, not found %0d",
                 status_tally[ST_OK], status_tally[ST_MISMATCH], status_tally[ST_OVERFLOW],
                 status_tally[ST_FULL], status_tally[ST_NOTFOUND]);
        if (mismatch_count == 0 && reports_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
